// File: rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared sizes, codes and types for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Pool dimensions.
  localparam int MAX_SLABS    = 16;
  localparam int MAX_ENTRIES  = 4096;
  localparam int HEADER_BYTES = 8;

  // Field widths.
  localparam int ENTRY_W  = 12;
  localparam int COUNT_W  = ENTRY_W + 1;
  localparam int SLAB_W   = 4;
  localparam int OPEN_W   = SLAB_W + 1;
  localparam int OFFSET_W = 24;
  localparam int BB_W     = 16;
  localparam int BPS_W    = 9;
  localparam int STATUS_W = 2;
  localparam int SCALE_W  = BB_W + 1;
  localparam int PROD_W   = BPS_W + SCALE_W;

  // Divider sizing: one quotient bit per step.
  localparam int DIV_STEPS = ENTRY_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Request codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Register indexes.
  localparam logic REG_BLOCK_BYTES     = 1'b0;
  localparam logic REG_BLOCKS_PER_SLAB = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OOM      = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_SCALE
  } state_t;

  // Divider result bundle.
  typedef struct packed {
    logic               done;
    logic [ENTRY_W-1:0] quotient;
    logic [BPS_W-1:0]   remainder;
  } div_result_t;

endpackage

// File: rtl/fbpa_stack_ram.sv
// ----------------------------------------------------------------------------
// fbpa_stack_ram
// Single-port storage for the stack of freed entry numbers, registered read.
// ----------------------------------------------------------------------------
module fbpa_stack_ram import fbpa_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [ENTRY_W-1:0] addr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fbpa_divider.sv
// ----------------------------------------------------------------------------
// fbpa_divider
// Restoring divider: entry number by slab size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_divider import fbpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ENTRY_W-1:0] dividend,
  input  logic [BPS_W-1:0]   divisor,
  output div_result_t        result
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BPS_W-1:0]     rem_r, rem_nxt;
  logic [ENTRY_W-1:0]   quo_r, quo_nxt;
  logic [BPS_W-1:0]     dvs_r, dvs_nxt;
  logic [BPS_W:0]       trial;
  logic [BPS_W:0]       diff;
  logic                 fits;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_r, quo_r[ENTRY_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Step control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[BPS_W-1:0] : trial[BPS_W-1:0];
      quo_nxt = {quo_r[ENTRY_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign result.done      = done_r;
  assign result.quotient  = quo_r;
  assign result.remainder = rem_r;

endmodule

// File: rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool manager with a LIFO free stack and a fresh cursor.
//
//   Channel   Ports                                  Handshake
//   input     in_func, in_free_entry                 start && !busy
//   result    out_entry_number .. out_slabs_open     out_valid, one cycle
//   config    psel, penable, pwrite, paddr, pwdata   APB, pready tied high
//
// A free is answered from idle. An allocate reads the stack top first when
// the stack is not empty, then runs 12 shared divider steps for slab and
// position, takes the quotient and scales. One past the last slab ends with
// OOM after the divide, one with every entry number used without a divide.
// Reset is synchronous; the free stack memory is not cleared.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel.
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [ENTRY_W-1:0]    in_free_entry,
  // Result channel.
  output logic                  out_valid,
  output logic [ENTRY_W-1:0]    out_entry_number,
  output logic [SLAB_W-1:0]     out_slab_number,
  output logic [OFFSET_W-1:0]   out_byte_offset,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OPEN_W-1:0]     out_slabs_open,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   cursor_r, cursor_nxt;
  logic [OPEN_W-1:0]    open_r, open_nxt;
  logic [BB_W-1:0]      bb_r;
  logic [BPS_W-1:0]     bps_r;
  logic                 from_cursor_r, from_cursor_nxt;
  logic [ENTRY_W-1:0]   entry_r, entry_nxt;
  logic [SLAB_W-1:0]    slab_r, slab_nxt;
  logic [BPS_W-1:0]     rem_r, rem_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0]   out_entry_r, out_entry_nxt;
  logic [SLAB_W-1:0]    out_slab_r, out_slab_nxt;
  logic [OFFSET_W-1:0]  out_offset_r, out_offset_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [OPEN_W-1:0]    out_open_r, out_open_nxt;

  logic                 accept;
  logic                 cfg_write;
  logic [BPS_W-1:0]     bps_eff;
  logic                 mem_we, mem_re;
  logic [ENTRY_W-1:0]   mem_addr, mem_wdata, mem_rdata;
  logic                 div_start;
  logic [ENTRY_W-1:0]   div_dividend;
  div_result_t          div_res;
  logic [PROD_W-1:0]    prod;
  logic [OPEN_W-1:0]    slab_next_open;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign bps_eff   = (bps_r == '0) ? BPS_W'(1) : bps_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r  <= BB_W'(8);
      bps_r <= BPS_W'(64);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_BLOCK_BYTES:     bb_r  <= pwdata[BB_W-1:0];
        REG_BLOCKS_PER_SLAB: bps_r <= pwdata[BPS_W-1:0];
        default:             bb_r  <= bb_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_BLOCK_BYTES:     prdata = {{(CFG_DATA_W-BB_W){1'b0}}, bb_r};
      REG_BLOCKS_PER_SLAB: prdata = {{(CFG_DATA_W-BPS_W){1'b0}}, bps_r};
      default:             prdata = '0;
    endcase
  end

  // Free stack storage.
  fbpa_stack_ram u_stack (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Shared divider for slab number and position within the slab.
  fbpa_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bps_eff),
    .result   (div_res)
  );

  // Position within slab scaled by the entry stride.
  assign prod = rem_r * (SCALE_W'(bb_r) + SCALE_W'(HEADER_BYTES));

  assign slab_next_open = OPEN_W'(div_res.quotient[SLAB_W-1:0]) + 1'b1;

  // Sequencer: next state, memory and divider control, result.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    cursor_nxt      = cursor_r;
    open_nxt        = open_r;
    from_cursor_nxt = from_cursor_r;
    entry_nxt       = entry_r;
    slab_nxt        = slab_r;
    rem_nxt         = rem_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = count_r[ENTRY_W-1:0];
    mem_wdata       = in_free_entry;
    div_start       = 1'b0;
    div_dividend    = cursor_r[ENTRY_W-1:0];
    out_valid_nxt   = 1'b0;
    out_entry_nxt   = '0;
    out_slab_nxt    = '0;
    out_offset_nxt  = '0;
    out_status_nxt  = STATUS_OK;
    out_open_nxt    = open_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_FREE) begin
            // Free: push unless never handed out or stack is full.
            out_valid_nxt = 1'b1;
            if (({1'b0, in_free_entry} >= cursor_r) || count_r[COUNT_W-1]) begin
              out_status_nxt = STATUS_BAD_FREE;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end else if (count_r != '0) begin
            // Allocate from the stack top.
            count_nxt       = count_r - 1'b1;
            mem_re          = 1'b1;
            mem_addr        = count_nxt[ENTRY_W-1:0];
            from_cursor_nxt = 1'b0;
            state_nxt       = ST_READ;
          end else if (cursor_r[COUNT_W-1]) begin
            // Every entry number has been used.
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_OOM;
          end else begin
            // Allocate from the fresh cursor; slab check follows the divide.
            entry_nxt       = cursor_r[ENTRY_W-1:0];
            div_start       = 1'b1;
            from_cursor_nxt = 1'b1;
            state_nxt       = ST_DIVIDE;
          end
        end
      end
      ST_READ: begin
        entry_nxt    = mem_rdata;
        div_dividend = mem_rdata;
        div_start    = 1'b1;
        state_nxt    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_res.done) begin
          if (from_cursor_r && (div_res.quotient[ENTRY_W-1:SLAB_W] != '0)) begin
            // Cursor lies beyond the last slab.
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_OOM;
            state_nxt      = ST_IDLE;
          end else begin
            if (from_cursor_r) begin
              cursor_nxt = cursor_r + 1'b1;
              if (slab_next_open > open_r) begin
                open_nxt = slab_next_open;
              end
            end
            slab_nxt  = div_res.quotient[SLAB_W-1:0];
            rem_nxt   = div_res.remainder;
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        out_valid_nxt  = 1'b1;
        out_entry_nxt  = entry_r;
        out_slab_nxt   = slab_r;
        out_offset_nxt = prod[OFFSET_W-1:0] + OFFSET_W'(HEADER_BYTES);
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      cursor_r      <= '0;
      open_r        <= OPEN_W'(1);
      from_cursor_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      cursor_r      <= cursor_nxt;
      open_r        <= open_nxt;
      from_cursor_r <= from_cursor_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    entry_r      <= entry_nxt;
    slab_r       <= slab_nxt;
    rem_r        <= rem_nxt;
    out_entry_r  <= out_entry_nxt;
    out_slab_r   <= out_slab_nxt;
    out_offset_r <= out_offset_nxt;
    out_status_r <= out_status_nxt;
    out_open_r   <= out_open_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_entry_number = out_entry_r;
  assign out_slab_number  = out_slab_r;
  assign out_byte_offset  = out_offset_r;
  assign out_status       = out_status_r;
  assign out_slabs_open   = out_open_r;

  // The stack never holds more entries than the pool has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_ENTRIES))
    else $error("free stack count exceeds pool size");

  // The open slab count stays between one and the slab limit.
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r != '0) && (open_r <= OPEN_W'(MAX_SLABS)))
    else $error("open slab count out of range");

  // A dropped free leaves the stack untouched.
  a_bad_free_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STATUS_BAD_FREE)) |-> $stable(count_r))
    else $error("bad free changed the stack");

  // The divider only finishes while the sequencer waits on it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIVIDE))
    else $error("divider finished outside the divide step");

endmodule
